>>> hw/rtl/amx_pkg.sv
// Shared types, constants and mixing functions of the and-mix xor-rotate generator.
package amx_pkg;

  localparam logic [63:0] DefaultSeed  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SeedK1       = 64'h6A09E667F3BCC908;
  localparam logic [63:0] SeedK2       = 64'h3243F6A8885A308D;
  localparam logic [63:0] SeedK3       = 64'hB7E151628AED2A6B;
  localparam logic [7:0]  WarmupReset  = 8'd22;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  typedef enum logic {
    REQ_DRAW = 1'b0,
    REQ_SEED = 1'b1
  } req_e;

  // One queued request
  typedef struct packed {
    req_e        kind;
    logic [63:0] seed;
  } req_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  // Generator state
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } state_t;

  // Rotate left by a fixed amount, 1..63
  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // Four-stage rotate-AND-xor mix
  function automatic logic [63:0] mix4(input logic [63:0] v);
    logic [63:0] t;
    t = v;
    t = t ^ (rotl(t, 31) & rotl(t, 53));
    t = t ^ (rotl(t, 17) & rotl(t, 43));
    t = t ^ (rotl(t, 7)  & rotl(t, 23));
    t = t ^ (rotl(t, 5)  & rotl(t, 19));
    return t;
  endfunction

  function automatic logic [63:0] word_step(input logic [63:0] v);
    return mix4(v ^ rotl(v, 22) ^ rotl(v, 26));
  endfunction

  // One state round
  function automatic state_t advance(input state_t s);
    state_t r;
    r.a = word_step(s.a ^ rotl(s.b, 5)  ^ rotl(s.c, 13));
    r.b = word_step(s.b ^ rotl(s.c, 11) ^ rotl(s.d, 19));
    r.c = word_step(s.c ^ rotl(s.d, 23) ^ rotl(s.a, 9));
    r.d = word_step(s.d ^ rotl(s.a, 17) ^ rotl(s.b, 27));
    return r;
  endfunction

  function automatic state_t expand_seed(input logic [63:0] s);
    state_t r;
    r.a = s;
    r.b = s ^ SeedK1;
    r.c = s ^ SeedK2;
    r.d = s ^ SeedK3;
    return r;
  endfunction

  // Output word from the current state
  function automatic logic [63:0] draw_word(input state_t s);
    logic [63:0] t;
    t = s.a ^ rotl(s.b, 32) ^ s.c ^ rotl(s.d, 16);
    t = t ^ rotl(t, 27) ^ rotl(t, 17);
    t = mix4(t);
    t = t ^ (t >> 32);
    return t;
  endfunction

endpackage

>>> hw/rtl/amx_front.sv
// Front end: accepts requests, tags them draw or seed, and queues them for the back end.
module amx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [63:0]        seed_value_i,
  output amx_pkg::qhead_t    head_o,
  input  logic               pop_i
);

  amx_pkg::req_t                     mem_q [amx_pkg::QueueDepth];
  logic [amx_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [amx_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [amx_pkg::QueueCntW-1:0]     count_q, count_d;
  logic                              push;
  amx_pkg::req_t                     new_req;

  // Classify the incoming request
  always_comb begin
    new_req.kind = amx_pkg::req_e'(req_type_i);
    new_req.seed = seed_value_i;
  end

  assign in_ready_o = (count_q != amx_pkg::QueueCntW'(amx_pkg::QueueDepth));
  assign push       = in_valid_i & in_ready_o;

  assign head_o.valid = (count_q != '0);
  assign head_o.req   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == amx_pkg::QueuePtrW'(amx_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == amx_pkg::QueuePtrW'(amx_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_req;
    end
  end

endmodule

>>> hw/rtl/amx_core.sv
// Back end: generator state, warm-up sequencing, warm-up register and output register.
module amx_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amx_pkg::qhead_t    head_i,
  output logic               pop_o,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        random_word_o
);

  amx_pkg::state_t state_q, state_d;
  logic [7:0]      warmup_q;
  logic [7:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     word_q;
  logic            slot_free;
  logic            pop_draw;

  assign slot_free = !out_valid_q || out_ready_i;

  // Take the head request when idle; a draw also needs the output slot
  assign pop_o = head_i.valid && !busy_q &&
                 ((head_i.req.kind == amx_pkg::REQ_SEED) || slot_free);
  assign pop_draw = pop_o && (head_i.req.kind == amx_pkg::REQ_DRAW);

  // State update, warm-up counting, output slot
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (busy_q) begin
      state_d = amx_pkg::advance(state_q);
      cnt_d   = cnt_q - 1'b1;
      busy_d  = (cnt_q != 8'd1);
    end else if (pop_o) begin
      case (head_i.req.kind)
        amx_pkg::REQ_SEED: begin
          state_d = amx_pkg::expand_seed(head_i.req.seed);
          cnt_d   = warmup_q;
          busy_d  = (warmup_q != 8'd0);
        end
        amx_pkg::REQ_DRAW: begin
          state_d     = amx_pkg::advance(state_q);
          out_valid_d = 1'b1;
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amx_pkg::expand_seed(amx_pkg::DefaultSeed);
      warmup_q    <= amx_pkg::WarmupReset;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        warmup_q <= cfg_data_i;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (pop_draw) begin
      word_q <= amx_pkg::draw_word(state_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

endmodule

>>> hw/rtl/andmix_xor_rotate_prng_top.sv
// Top level of the and-mix xor-rotate pseudo-random generator.
// A draw passes the queue stage, then the output register, before its result shows.
// Throughput: one draw per cycle unless a warm-up runs or the output is stalled.
// A seed request holds the back end while it runs warmup_rounds full rounds, one per cycle.
// Reset (async, active low) loads the default seed expansion with no warm-up,
// sets warmup_rounds to 22 and empties the queue and output register.
module andmix_xor_rotate_prng_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [63:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] random_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  amx_pkg::qhead_t head;
  logic            pop;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  amx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .seed_value_i (seed_value_i),
    .head_o       (head),
    .pop_i        (pop)
  );

  amx_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_o (random_word_o)
  );

endmodule

>>> hw/rtl/amx_checker.sv
// Port-level checks for the generator top level, bound to it.
module amx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        req_type_i,
  input logic [63:0] seed_value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] random_word_o,
  input logic        cfg_ready_o
);

  // A stalled result holds its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(random_word_o))
    else $error("result changed while stalled");

  // Coming out of reset the queue has room for a request and no result is shown
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("queue or result not cleared by reset");

  // A waiting request keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(req_type_i) && $stable(seed_value_i))
    else $error("request changed while waiting");

  // Register writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("register write stalled");

endmodule

bind andmix_xor_rotate_prng_top amx_checker u_amx_checker (.*);

>>> sim/amx_word_checker.sv
// Draw-word predictor and result comparison for the and-mix xor-rotate generator.
`timescale 1ns / 1ps

module amx_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [63:0] seed_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] random_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  amx_pkg::state_t gen_state;
  logic [7:0]      warmup_q;
  logic [63:0]     pending_draws[$];
  int unsigned     errs;

  // Left rotate through a doubled word; n = 0 leaves v as is
  function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned n);
    logic [127:0] dbl;
    dbl = {v, v} << n;
    return dbl[127:64];
  endfunction

  function automatic logic [63:0] and_mix(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ (rol64(x, 31) & rol64(x, 53));
    x = x ^ (rol64(x, 17) & rol64(x, 43));
    x = x ^ (rol64(x, 7) & rol64(x, 23));
    x = x ^ (rol64(x, 5) & rol64(x, 19));
    return x;
  endfunction

  function automatic logic [63:0] churn(input logic [63:0] v);
    return and_mix(v ^ rol64(v, 22) ^ rol64(v, 26));
  endfunction

  // One full round: cross-mix the four words, then churn each
  function automatic amx_pkg::state_t next_round(input amx_pkg::state_t s);
    amx_pkg::state_t n;
    n.a = churn(s.a ^ rol64(s.b, 5) ^ rol64(s.c, 13));
    n.b = churn(s.b ^ rol64(s.c, 11) ^ rol64(s.d, 19));
    n.c = churn(s.c ^ rol64(s.d, 23) ^ rol64(s.a, 9));
    n.d = churn(s.d ^ rol64(s.a, 17) ^ rol64(s.b, 27));
    return n;
  endfunction

  function automatic amx_pkg::state_t spread_seed(input logic [63:0] seed);
    amx_pkg::state_t n;
    n.a = seed;
    n.b = seed ^ amx_pkg::SeedK1;
    n.c = seed ^ amx_pkg::SeedK2;
    n.d = seed ^ amx_pkg::SeedK3;
    return n;
  endfunction

  // Output word of the current state, before the state moves on
  function automatic logic [63:0] fold_word(input amx_pkg::state_t s);
    logic [63:0] w;
    w = s.a ^ rol64(s.b, 32) ^ s.c ^ rol64(s.d, 16);
    w = w ^ rol64(w, 27) ^ rol64(w, 17);
    w = and_mix(w);
    return w ^ {32'h0, w[63:32]};
  endfunction

  // Track config and requests, compare every accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    int unsigned k;
    if (!rst_ni) begin
      gen_state = spread_seed(amx_pkg::DefaultSeed);
      warmup_q  = amx_pkg::WarmupReset;
      pending_draws.delete();
      errs = 0;
      pending_o   <= 0;
      err_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        warmup_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_draws.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: unexpected random_word %h", $realtime, random_word_i);
        end else begin
          want = pending_draws.pop_front();
          if (want !== random_word_i) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: random_word expected %h got %h", $realtime, want, random_word_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (amx_pkg::req_e'(req_type_i) == amx_pkg::REQ_SEED) begin
          gen_state = spread_seed(seed_value_i);
          for (k = 0; k < warmup_q; k++) gen_state = next_round(gen_state);
        end else begin
          pending_draws.push_back(fold_word(gen_state));
          gen_state = next_round(gen_state);
        end
      end
      pending_o   <= pending_draws.size();
      err_count_o <= errs;
    end
  end

endmodule

>>> sim/tb_andmix_xor_rotate_prng_top.sv
// Stimulus, watchdog and verdict for the and-mix xor-rotate generator.
`timescale 1ns / 1ps

module tb_andmix_xor_rotate_prng_top;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned HoldAfter  = 300;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        req_type_i   = 1'b0;
  logic [63:0] seed_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [63:0] random_word_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i   = '0;

  int unsigned err_count;
  int unsigned pending;
  int unsigned quiet;
  int unsigned cur_warmup;
  int unsigned sent;
  bit          in_calm;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  andmix_xor_rotate_prng_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .seed_value_i  (seed_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_o (random_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  amx_word_checker word_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .req_type_i    (req_type_i),
    .seed_value_i  (seed_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_i (random_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // Offer one request, with an optional idle gap first; returns at its accepting edge
  task automatic send_req(input amx_pkg::req_e kind, input logic [63:0] seed);
    int unsigned gap;
    if (sent % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
    sent++;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering, let every word come back, then cover the warm-ups still running
  // or queued: one in the back end and up to two waiting in the queue
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3 * (cur_warmup + 1) + 8) @(posedge clk_i);
  endtask

  task automatic write_warmup(input logic [7:0] rounds);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rounds;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_warmup  = rounds;
  endtask

  // Mostly draws, one seed request in about seed_odds
  task automatic run_random(input int unsigned count, input int unsigned seed_odds);
    amx_pkg::req_e kind;
    logic [63:0]   seed;
    repeat (count) begin
      kind = ($urandom_range(0, seed_odds - 1) == 0) ? amx_pkg::REQ_SEED : amx_pkg::REQ_DRAW;
      case ($urandom_range(0, 9))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = {$urandom, $urandom};
      endcase
      send_req(kind, seed);
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == HoldAfter) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  // Watchdog on cycles with no request moving on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Main sequence
  initial begin
    quiet      = 0;
    sent       = 0;
    in_calm    = 1'b0;
    cur_warmup = amx_pkg::WarmupReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset state and default warm-up; seed_value ignored on draws
    send_req(amx_pkg::REQ_DRAW, '0);
    send_req(amx_pkg::REQ_DRAW, '1);
    send_req(amx_pkg::REQ_DRAW, {$urandom, $urandom});
    wait_drained();
    send_req(amx_pkg::REQ_SEED, '0);
    send_req(amx_pkg::REQ_DRAW, '1);
    send_req(amx_pkg::REQ_SEED, '1);
    send_req(amx_pkg::REQ_DRAW, '0);
    send_req(amx_pkg::REQ_DRAW, {$urandom, $urandom});
    send_req(amx_pkg::REQ_SEED, 64'h8000_0000_0000_0001);
    send_req(amx_pkg::REQ_DRAW, '0);

    // zero warm-up: expanded seed used directly
    write_warmup(8'd0);
    send_req(amx_pkg::REQ_SEED, 64'h0123_4567_89AB_CDEF);
    send_req(amx_pkg::REQ_DRAW, '0);
    send_req(amx_pkg::REQ_SEED, amx_pkg::DefaultSeed);
    send_req(amx_pkg::REQ_DRAW, '1);
    send_req(amx_pkg::REQ_SEED, '0);
    send_req(amx_pkg::REQ_DRAW, '0);
    send_req(amx_pkg::REQ_DRAW, '0);

    // longest warm-up
    write_warmup(8'd255);
    send_req(amx_pkg::REQ_SEED, {$urandom, $urandom});
    send_req(amx_pkg::REQ_DRAW, '0);
    send_req(amx_pkg::REQ_DRAW, '1);
    run_random(200, 25);

    write_warmup(8'd1);
    run_random(400, 6);

    write_warmup(8'($urandom_range(2, 254)));
    run_random(400, 12);

    write_warmup(amx_pkg::WarmupReset);
    run_random(400, 8);

    wait_drained();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
